/* design/ibmw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_pkg
// Shared types and constants for the inode block map walker.
// ----------------------------------------------------------------------------
package ibmw_pkg;

  localparam int unsigned SlotCount  = 13;
  localparam int unsigned PtrW       = 24;
  localparam int unsigned BlockW     = 28;
  localparam int unsigned WordW      = 32;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned OffsetW    = 27;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 32;

  // first block past the end of each range
  localparam logic [BlockW-1:0] DirectEnd = 28'd10;
  localparam logic [BlockW-1:0] SingleEnd = 28'd522;
  localparam logic [BlockW-1:0] DoubleEnd = 28'd262666;
  localparam logic [BlockW-1:0] TripleEnd = 28'd134480394;

  localparam logic [3:0] SlotSingle = 4'd10;
  localparam logic [3:0] SlotDouble = 4'd11;
  localparam logic [3:0] SlotTriple = 4'd12;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PTR_PAIR_0   = 3'd0,
    REG_PTR_PAIR_1   = 3'd1,
    REG_PTR_PAIR_2   = 3'd2,
    REG_PTR_PAIR_3   = 3'd3,
    REG_PTR_PAIR_4   = 3'd4,
    REG_PTR_PAIR_5   = 3'd5,
    REG_TRIPLE_ROOT  = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_READ       = 3'd0,
    KIND_FINAL      = 3'd1,
    KIND_RANGE      = 3'd2,
    KIND_BUSY       = 3'd3,
    KIND_UNEXPECTED = 3'd4
  } kind_t;

  typedef enum logic {
    ACT_TRANSLATE = 1'b0,
    ACT_WORD      = 1'b1
  } action_t;

  typedef logic [SlotCount-1:0][PtrW-1:0] slot_arr_t;

  typedef struct packed {
    kind_t            kind;
    logic [AddrW-1:0] address;
  } result_t;

  typedef struct packed {
    logic [1:0] levels_left;
    logic       walking;
  } walk_stat_t;

endpackage

/* design/ibmw_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_cfg
// Inode pointer slot registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module ibmw_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [ibmw_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [ibmw_pkg::CfgDataW-1:0]      cfg_data,
  output ibmw_pkg::slot_arr_t                slots
);

  ibmw_pkg::slot_arr_t slots_r;
  ibmw_pkg::slot_arr_t slots_nxt;

  always_comb begin
    slots_nxt = slots_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ibmw_pkg::REG_PTR_PAIR_0: begin
          slots_nxt[0] = cfg_data[23:0];
          slots_nxt[1] = cfg_data[47:24];
        end
        ibmw_pkg::REG_PTR_PAIR_1: begin
          slots_nxt[2] = cfg_data[23:0];
          slots_nxt[3] = cfg_data[47:24];
        end
        ibmw_pkg::REG_PTR_PAIR_2: begin
          slots_nxt[4] = cfg_data[23:0];
          slots_nxt[5] = cfg_data[47:24];
        end
        ibmw_pkg::REG_PTR_PAIR_3: begin
          slots_nxt[6] = cfg_data[23:0];
          slots_nxt[7] = cfg_data[47:24];
        end
        ibmw_pkg::REG_PTR_PAIR_4: begin
          slots_nxt[8] = cfg_data[23:0];
          slots_nxt[9] = cfg_data[47:24];
        end
        ibmw_pkg::REG_PTR_PAIR_5: begin
          slots_nxt[10] = cfg_data[23:0];
          slots_nxt[11] = cfg_data[47:24];
        end
        ibmw_pkg::REG_TRIPLE_ROOT: begin
          slots_nxt[12] = cfg_data[23:0];
        end
        default: begin
          slots_nxt = slots_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
    end else begin
      slots_r <= slots_nxt;
    end
  end

  assign slots = slots_r;

endmodule

/* design/ibmw_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_walk
// Walk state and the single-pass translate / returned-word logic.
// ----------------------------------------------------------------------------
module ibmw_walk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  ibmw_pkg::action_t               action,
  input  logic [ibmw_pkg::BlockW-1:0]     block_number,
  input  logic [ibmw_pkg::WordW-1:0]      read_word,
  input  ibmw_pkg::slot_arr_t             slots,
  output ibmw_pkg::result_t               res,
  output ibmw_pkg::walk_stat_t            stat
);

  logic [1:0]                     levels_r;
  logic [1:0]                     levels_nxt;
  logic [ibmw_pkg::OffsetW-1:0]   offset_r;
  logic [ibmw_pkg::OffsetW-1:0]   offset_nxt;

  logic [ibmw_pkg::BlockW-1:0]    off_single;
  logic [ibmw_pkg::BlockW-1:0]    off_double;
  logic [ibmw_pkg::BlockW-1:0]    off_triple;
  logic [ibmw_pkg::WordW-1:0]     swapped;
  logic [8:0]                     idx;
  logic [ibmw_pkg::PtrW-1:0]      root;

  assign off_single = block_number - ibmw_pkg::DirectEnd;
  assign off_double = block_number - ibmw_pkg::SingleEnd;
  assign off_triple = block_number - ibmw_pkg::DoubleEnd;
  assign swapped    = {read_word[7:0], read_word[15:8], read_word[23:16], read_word[31:24]};

  always_comb begin
    levels_nxt  = levels_r;
    offset_nxt  = offset_r;
    idx         = '0;
    root        = '0;
    res.kind    = ibmw_pkg::KIND_BUSY;
    res.address = '0;
    if (action == ibmw_pkg::ACT_TRANSLATE) begin
      priority if (levels_r != 2'd0) begin
        res.kind = ibmw_pkg::KIND_BUSY;
      end else if (block_number >= ibmw_pkg::TripleEnd) begin
        res.kind = ibmw_pkg::KIND_RANGE;
      end else if (block_number < ibmw_pkg::DirectEnd) begin
        root        = slots[block_number[3:0]];
        res.kind    = ibmw_pkg::KIND_FINAL;
        res.address = {root, 8'd0};
      end else if (block_number < ibmw_pkg::SingleEnd) begin
        levels_nxt  = 2'd1;
        offset_nxt  = off_single[ibmw_pkg::OffsetW-1:0];
        idx         = off_single[8:0];
        root        = slots[ibmw_pkg::SlotSingle];
        res.kind    = ibmw_pkg::KIND_READ;
        res.address = {root, 8'd0} + {21'd0, idx, 2'd0};
      end else if (block_number < ibmw_pkg::DoubleEnd) begin
        levels_nxt  = 2'd2;
        offset_nxt  = off_double[ibmw_pkg::OffsetW-1:0];
        idx         = off_double[17:9];
        root        = slots[ibmw_pkg::SlotDouble];
        res.kind    = ibmw_pkg::KIND_READ;
        res.address = {root, 8'd0} + {21'd0, idx, 2'd0};
      end else begin
        levels_nxt  = 2'd3;
        offset_nxt  = off_triple[ibmw_pkg::OffsetW-1:0];
        idx         = off_triple[26:18];
        root        = slots[ibmw_pkg::SlotTriple];
        res.kind    = ibmw_pkg::KIND_READ;
        res.address = {root, 8'd0} + {21'd0, idx, 2'd0};
      end
    end else begin
      unique case (levels_r)
        2'd0: begin
          res.kind = ibmw_pkg::KIND_UNEXPECTED;
        end
        2'd1: begin
          levels_nxt  = 2'd0;
          res.kind    = ibmw_pkg::KIND_FINAL;
          res.address = swapped;
        end
        2'd2: begin
          levels_nxt  = 2'd1;
          idx         = offset_r[8:0];
          res.kind    = ibmw_pkg::KIND_READ;
          res.address = swapped + {21'd0, idx, 2'd0};
        end
        default: begin
          levels_nxt  = 2'd2;
          idx         = offset_r[17:9];
          res.kind    = ibmw_pkg::KIND_READ;
          res.address = swapped + {21'd0, idx, 2'd0};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= 2'd0;
      offset_r <= '0;
    end else if (step) begin
      levels_r <= levels_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign stat.levels_left = levels_r;
  assign stat.walking     = (levels_r != 2'd0);

endmodule

/* design/inode_block_map_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inode_block_map_walker
// Maps a logical file block to a disk byte address through the inode's
// direct, single, double and triple indirect pointers, one item per cycle while out_tready is high.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tuser action, tdata block_number / read_word
//  out_    | out | tuser kind, tdata address
//  cfg_    | in  | cfg_index register, cfg_data value
//
// each item passes through the input register and then the result register;
// one item per cycle sustained while out_tready holds high
// the walk state is updated as an item moves into the result register
// the input side keeps accepting while a result waits, until both stages hold
// reset clears pointers, walk state and both valid flags; cfg_ready stays high
// ----------------------------------------------------------------------------
module inode_block_map_walker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ibmw_pkg::InDataW-1:0]      in_tdata,   // block_number, read_word
  input  logic                              in_tuser,   // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ibmw_pkg::OutDataW-1:0]     out_tdata,  // address
  output logic [2:0]                        out_tuser,  // kind
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ibmw_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [ibmw_pkg::CfgDataW-1:0]     cfg_data
);

  logic                             in_v_r;
  logic                             in_v_nxt;
  ibmw_pkg::action_t                act_r;
  logic [ibmw_pkg::BlockW-1:0]      bn_r;
  logic [ibmw_pkg::WordW-1:0]       word_r;
  logic                             out_v_r;
  logic                             out_v_nxt;
  ibmw_pkg::result_t                out_r;
  ibmw_pkg::result_t                res;
  ibmw_pkg::walk_stat_t             stat;
  ibmw_pkg::slot_arr_t              slots;
  logic                             out_free;
  logic                             step;
  logic                             in_acc;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_v_r || out_tready;
  assign step      = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  ibmw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .slots     (slots)
  );

  ibmw_walk u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .action       (act_r),
    .block_number (bn_r),
    .read_word    (word_r),
    .slots        (slots),
    .res          (res),
    .stat         (stat)
  );

  always_comb begin
    in_v_nxt  = in_acc || (in_v_r && !step);
    out_v_nxt = step || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= ibmw_pkg::action_t'(in_tuser);
      bn_r   <= in_tdata[27:0];
      word_r <= in_tdata[59:28];
    end
    if (step) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.address;
  assign out_tuser  = out_r.kind;

`ifndef SYNTHESIS
  a_flag_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ibmw_pkg::KIND_RANGE || out_tuser == ibmw_pkg::KIND_BUSY ||
                   out_tuser == ibmw_pkg::KIND_UNEXPECTED) |-> out_tdata == '0)
    else $error("flagged item carries a non-zero address");

  a_busy_while_walking: assert property (@(posedge clk) disable iff (!rst_n)
    step && stat.walking && act_r == ibmw_pkg::ACT_TRANSLATE |=> out_r.kind == ibmw_pkg::KIND_BUSY)
    else $error("translate during a walk not answered busy");

  a_final_word_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    step && act_r == ibmw_pkg::ACT_WORD && stat.levels_left == 2'd1 |=> !stat.walking)
    else $error("walk still pending after last indirect word");

  a_idle_word_unexpected: assert property (@(posedge clk) disable iff (!rst_n)
    step && !stat.walking && act_r == ibmw_pkg::ACT_WORD
    |=> out_r.kind == ibmw_pkg::KIND_UNEXPECTED && !stat.walking)
    else $error("word while idle not flagged");
`endif

endmodule
